@@ design/fdtd_pkg.sv @@
// ----------------------------------------------------------------------------
// fdtd_pkg: shared constants, types and helpers of the 1-D FDTD field update
// Mesh size, fixed-point layout, register indexes and the per-cell control
// group that the top level hands to each mesh cell.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  localparam int MESH_CELLS = 64;
  localparam int FIELD_BITS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_E_BITS = 20;
  localparam int IDX_BITS   = $clog2(MESH_CELLS);
  localparam int CNT_BITS   = $clog2(MESH_CELLS + 1);
  localparam int WIDE_BITS  = 56;

  localparam logic [1:0] CFG_COUPLING      = 2'd0;
  localparam logic [1:0] CFG_SOURCE_CELL   = 2'd1;
  localparam logic [1:0] CFG_SAVE_INTERVAL = 2'd2;

  localparam logic [15:0] COUPLING_RST      = 16'd32768;
  localparam logic [5:0]  SOURCE_CELL_RST   = 6'd32;
  localparam logic [15:0] SAVE_INTERVAL_RST = 16'd20;

  typedef struct packed {
    logic upd_e;      // apply E update in this cycle
    logic force_src;  // overwrite E with the source value
    logic upd_h;      // apply H update in this cycle
    logic snap_load;  // copy E into the snapshot line
    logic snap_shift; // advance the snapshot line towards cell 0
  } cell_ctrl_t;

  // saturate a wide signed value to a signed range of the given width
  function automatic logic signed [WIDE_BITS-1:0] sat_wide(
    input logic signed [WIDE_BITS-1:0] v,
    input int                          bits
  );
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = (WIDE_BITS'(1) <<< (bits - 1)) - WIDE_BITS'(1);
    lo = -hi - WIDE_BITS'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

@@ design/fdtd_1d_field_update_unit.sv @@
// ----------------------------------------------------------------------------
// fdtd_1d_field_update_unit: 1-D Yee field update over a chain of mesh cells
// Each input item is one time step carrying the hard source value; every
// save_interval steps the E field is streamed out, one cell per item.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid_i, in_stall_o, source_value_i | in
//  output   | out_valid_o, out_stall_i, cell_index_o,| out
//           | e_value_o, snapshot_number_o, last_cell_o
//  config   | cfg_we_i, cfg_addr_i, cfg_wdata_i      | in
//
// A step runs through accept, an E phase over all cells and an H phase over all
// cells; every cell has its own coupling multiplier. A snapshot step adds a save
// state to copy E into the snapshot line, which then shifts out one cell per
// cycle unless the output stalls, while later steps run; the copy waits for the
// previous run to finish. Reset clears E, H and the snapshot number at once.
// Output stall holds the snapshot line and the output fields.
// ----------------------------------------------------------------------------
module fdtd_1d_field_update_unit import fdtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] source_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         cell_index_o,
  output logic signed [19:0] e_value_o,
  output logic [15:0]        snapshot_number_o,
  output logic               last_cell_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_UPD_E = 2'd1;
  localparam logic [1:0] ST_UPD_H = 2'd2;
  localparam logic [1:0] ST_SAVE  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [15:0] coupling_q;
  logic [5:0]  source_cell_q;
  logic [15:0] save_interval_q;
  logic [15:0] steps_q, steps_d;
  logic [15:0] snap_num_q, snap_num_d;
  logic        emit_q, emit_d;
  logic [IDX_BITS-1:0] out_cnt_q, out_cnt_d;
  logic signed [FIELD_BITS-1:0] src_q;
  logic signed [WIDE_BITS-1:0]  src_sat, e_out_sat;
  logic [15:0] reload;
  logic        in_acc, out_acc, load_snap;

  logic signed [FIELD_BITS-1:0] e_vec    [MESH_CELLS];
  logic signed [FIELD_BITS-1:0] h_vec    [MESH_CELLS];
  logic signed [FIELD_BITS-1:0] snap_vec [MESH_CELLS];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = emit_q && !out_stall_i;
  assign load_snap  = (state_q == ST_SAVE) && !emit_q;
  assign reload     = (save_interval_q == 16'd0) ? 16'd0 : save_interval_q - 16'd1;
  assign src_sat    = sat_wide(WIDE_BITS'(source_value_i), FIELD_BITS);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q      <= COUPLING_RST;
      source_cell_q   <= SOURCE_CELL_RST;
      save_interval_q <= SAVE_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_COUPLING:      coupling_q      <= cfg_wdata_i;
        CFG_SOURCE_CELL:   source_cell_q   <= cfg_wdata_i[5:0];
        CFG_SAVE_INTERVAL: save_interval_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    steps_d    = steps_q;
    snap_num_d = snap_num_q;
    emit_d     = emit_q;
    out_cnt_d  = out_cnt_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_UPD_E;
      ST_UPD_E: state_d = ST_UPD_H;
      ST_UPD_H: begin
        if (steps_q == 16'd0) begin
          steps_d = reload;
          state_d = ST_SAVE;
        end else begin
          steps_d = steps_q - 16'd1;
          state_d = ST_IDLE;
        end
      end
      ST_SAVE:  if (!emit_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    if (load_snap) begin
      emit_d     = 1'b1;
      out_cnt_d  = '0;
      snap_num_d = snap_num_q + 16'd1;
    end else if (out_acc) begin
      out_cnt_d = out_cnt_q + IDX_BITS'(1);
      if (out_cnt_q == IDX_BITS'(MESH_CELLS - 1)) begin
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      steps_q    <= SAVE_INTERVAL_RST - 16'd1;
      snap_num_q <= '0;
      emit_q     <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      steps_q    <= steps_d;
      snap_num_q <= snap_num_d;
      emit_q     <= emit_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      src_q <= src_sat[FIELD_BITS-1:0];
    end
  end

  for (genvar g = 0; g < MESH_CELLS; g++) begin : g_cell
    cell_ctrl_t                   ctrl;
    logic signed [FIELD_BITS-1:0] h_left, e_right, snap_right;

    assign ctrl.upd_e      = (state_q == ST_UPD_E) && (g != 0);
    assign ctrl.force_src  = (state_q == ST_UPD_E) && (source_cell_q == 6'(g));
    assign ctrl.upd_h      = (state_q == ST_UPD_H) && (g != MESH_CELLS - 1);
    assign ctrl.snap_load  = load_snap;
    assign ctrl.snap_shift = out_acc;

    if (g == 0) begin : g_first
      assign h_left = '0;
    end else begin : g_mid
      assign h_left = h_vec[g-1];
    end
    if (g == MESH_CELLS - 1) begin : g_last
      assign e_right    = '0;
      assign snap_right = '0;
    end else begin : g_inner
      assign e_right    = e_vec[g+1];
      assign snap_right = snap_vec[g+1];
    end

    fdtd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .coupling_i   (coupling_q),
      .src_i        (src_q),
      .h_left_i     (h_left),
      .e_right_i    (e_right),
      .snap_right_i (snap_right),
      .e_o          (e_vec[g]),
      .h_o          (h_vec[g]),
      .snap_o       (snap_vec[g])
    );
  end

  assign e_out_sat         = sat_wide(WIDE_BITS'(snap_vec[0]), OUT_E_BITS);
  assign out_valid_o       = emit_q;
  assign cell_index_o      = 6'(out_cnt_q);
  assign e_value_o         = e_out_sat[OUT_E_BITS-1:0];
  assign snapshot_number_o = snap_num_q;
  assign last_cell_o       = (out_cnt_q == IDX_BITS'(MESH_CELLS - 1));

  a_e_then_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD_E |=> state_q == ST_UPD_H)
    else $error("E phase not followed by H phase");

  a_load_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_snap |=> emit_q && out_cnt_q == '0)
    else $error("snapshot copy did not start a fresh run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_cell_o |=> !emit_q)
    else $error("snapshot run continued past last cell");

  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q && state_q == ST_SAVE |=> $stable(snap_num_q))
    else $error("snapshot number changed during a run");

endmodule

@@ design/fdtd_cell.sv @@
// ----------------------------------------------------------------------------
// fdtd_cell: one mesh cell of the field update chain
// Holds E and H of one cell and one stage of the snapshot line. A single
// coupling multiplier serves the E phase and then the H phase.
// ----------------------------------------------------------------------------
module fdtd_cell import fdtd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctrl_t                   ctrl_i,
  input  logic [15:0]                  coupling_i,
  input  logic signed [FIELD_BITS-1:0] src_i,
  input  logic signed [FIELD_BITS-1:0] h_left_i,
  input  logic signed [FIELD_BITS-1:0] e_right_i,
  input  logic signed [FIELD_BITS-1:0] snap_right_i,
  output logic signed [FIELD_BITS-1:0] e_o,
  output logic signed [FIELD_BITS-1:0] h_o,
  output logic signed [FIELD_BITS-1:0] snap_o
);

  localparam int PROD_BITS = FIELD_BITS + 18;

  logic signed [FIELD_BITS-1:0] e_q, e_d;
  logic signed [FIELD_BITS-1:0] h_q, h_d;
  logic signed [FIELD_BITS-1:0] snap_q, snap_d;

  logic signed [FIELD_BITS-1:0] base, op_a, op_b, upd_val;
  logic signed [FIELD_BITS:0]   diff;
  logic signed [PROD_BITS-1:0]  prod, rnd, shifted;
  logic signed [WIDE_BITS-1:0]  sum, sum_sat;

  always_comb begin
    if (ctrl_i.upd_h) begin
      base = h_q;
      op_a = e_q;
      op_b = e_right_i;
    end else begin
      base = e_q;
      op_a = h_left_i;
      op_b = h_q;
    end
    diff    = (FIELD_BITS+1)'(op_a) - (FIELD_BITS+1)'(op_b);
    prod    = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, coupling_i}));
    // round to nearest, ties towards plus infinity
    rnd     = prod + (PROD_BITS'(1) <<< (FRAC_BITS - 1));
    shifted = rnd >>> FRAC_BITS;
    sum     = WIDE_BITS'(base) + WIDE_BITS'(shifted);
    sum_sat = sat_wide(sum, FIELD_BITS);
    upd_val = sum_sat[FIELD_BITS-1:0];
  end

  always_comb begin
    e_d = e_q;
    if (ctrl_i.force_src) begin
      e_d = src_i;
    end else if (ctrl_i.upd_e) begin
      e_d = upd_val;
    end
    h_d = ctrl_i.upd_h ? upd_val : h_q;
    snap_d = snap_q;
    if (ctrl_i.snap_load) begin
      snap_d = e_q;
    end else if (ctrl_i.snap_shift) begin
      snap_d = snap_right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
      h_q <= '0;
    end else begin
      e_q <= e_d;
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign e_o    = e_q;
  assign h_o    = h_q;
  assign snap_o = snap_q;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 1-D FDTD field update unit
// Steps of hard source values go in through a queue-fed driver. A mesh model
// kept here computes the E and H update of each step and the E snapshots
// expected from it. A monitor compares every streamed cell with the oldest
// snapshot sample still due. Registers change only between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdtd_pkg::*;

  localparam logic [1:0] CFG_SPARE     = 2'd3;  // no register behind it
  localparam int         SETTLE_CYCLES = 16;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         QUIET_LIMIT   = 5000;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct {
    logic [5:0]         cell_idx;
    logic signed [19:0] e_val;
    logic [15:0]        snap;
    logic               last;
  } e_sample_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_addr_i     = CFG_COUPLING;
  logic [15:0]        cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic signed [19:0] source_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [5:0]         cell_index_o;
  logic signed [19:0] e_value_o;
  logic [15:0]        snapshot_number_o;
  logic               last_cell_o;

  fdtd_1d_field_update_unit u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mesh model state and its copy of the registers
  field_t      e_cells [MESH_CELLS];
  field_t      h_cells [MESH_CELLS];
  logic [15:0] coupling_r;
  logic [5:0]  source_cell_r;
  logic [15:0] interval_r;
  logic [15:0] steps_left;
  logic [15:0] snapshots_taken;

  logic signed [19:0] steps_q [$];
  e_sample_t          e_samples_due [$];

  bit idle_on     = 1'b1;
  bit hold_wanted = 1'b0;
  bit hold_taken  = 1'b0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;

  function automatic field_t field_clip(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (FIELD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[FIELD_BITS-1:0];
  endfunction

  // base + coupling * (a - b), rounded half up to the fraction, saturated
  function automatic field_t coupled_sum(input field_t base, input field_t a,
                                         input field_t b);
    longint prod;
    longint delta;
    prod  = (longint'(a) - longint'(b)) * longint'(coupling_r);
    delta = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return field_clip(longint'(base) + delta);
  endfunction

  task automatic advance_mesh(input logic signed [19:0] src);
    e_sample_t s;
    for (int k = 1; k < MESH_CELLS; k++) begin
      e_cells[k] = coupled_sum(e_cells[k], h_cells[k-1], h_cells[k]);
    end
    if (int'(source_cell_r) < MESH_CELLS) begin
      e_cells[source_cell_r] = field_clip(longint'(src));
    end
    for (int k = 0; k < MESH_CELLS - 1; k++) begin
      h_cells[k] = coupled_sum(h_cells[k], e_cells[k], e_cells[k+1]);
    end
    if (steps_left != 0) begin
      steps_left = steps_left - 16'd1;
    end else begin
      // reload; an interval of zero behaves as one
      steps_left      = (interval_r == 0) ? 16'd0 : interval_r - 16'd1;
      snapshots_taken = snapshots_taken + 16'd1;
      for (int k = 0; k < MESH_CELLS; k++) begin
        s.cell_idx = 6'(k);
        s.e_val    = 20'(e_cells[k]);
        s.snap     = snapshots_taken;
        s.last     = (k == MESH_CELLS - 1);
        e_samples_due.push_back(s);
      end
    end
  endtask

  // driver: present queued steps, gap now and then, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_mesh(source_value_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (steps_q.size() != 0 && !(idle_on && $urandom_range(99) < 8)) begin
          in_valid_i     <= 1'b1;
          source_value_i <= steps_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall: random back-pressure plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_wanted && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin : monitor_blk
    e_sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (e_samples_due.size() == 0) begin
        $display("%0t: unexpected sample cell %0d e %0d snap %0d last %0b", $time,
                 cell_index_o, e_value_o, snapshot_number_o, last_cell_o);
        mismatches++;
      end else begin
        want = e_samples_due.pop_front();
        if (cell_index_o !== want.cell_idx || e_value_o !== want.e_val ||
            snapshot_number_o !== want.snap || last_cell_o !== want.last) begin
          $display("%0t: expected cell %0d e %0d snap %0d last %0b", $time,
                   want.cell_idx, want.e_val, want.snap, want.last);
          $display("%0t: actual   cell %0d e %0d snap %0d last %0b", $time,
                   cell_index_o, e_value_o, snapshot_number_o, last_cell_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    unique case (idx)
      CFG_COUPLING:      coupling_r    = val;
      CFG_SOURCE_CELL:   source_cell_r = val[5:0];
      CFG_SAVE_INTERVAL: interval_r    = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [19:0] pick_source();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      return 20'($urandom);
    end else if (sel == 1) begin
      return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
    end
    // mostly within plus or minus one
    return 20'(int'($urandom_range(131072)) - 65536);
  endfunction

  // wait for every step taken and every sample seen, then let the mesh settle
  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (steps_q.size() != 0 || in_valid_i || e_samples_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_steps(input int n);
    for (int i = 0; i < n; i++) begin
      steps_q.push_back(pick_source());
    end
  endtask

  initial begin
    for (int k = 0; k < MESH_CELLS; k++) begin
      e_cells[k] = '0;
      h_cells[k] = '0;
    end
    coupling_r      = COUPLING_RST;
    source_cell_r   = SOURCE_CELL_RST;
    interval_r      = SAVE_INTERVAL_RST;
    steps_left      = SAVE_INTERVAL_RST - 16'd1;
    snapshots_taken = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, field extremes, snapshot on the twentieth step
    steps_q = '{20'sh7FFFF, 20'sh80000, 20'sh00000, 20'sh00001, -20'sh00001,
                20'sh10000, -20'sh10000, 20'sh55555, 20'shAAAAA, 20'sh7FFFF,
                20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh08000, -20'sh08000,
                20'sh00000, 20'sh20000, -20'sh20000, 20'sh7FFFF, 20'sh80000};
    drain();

    // full coupling, source on the edge cell, interval zero, spare index
    write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_COUPLING, 16'hFFFF);
    write_reg(CFG_SOURCE_CELL, 16'd0);
    write_reg(CFG_SAVE_INTERVAL, 16'd0);
    idle_on = 1'b0;
    random_steps(24);
    drain();
    idle_on = 1'b1;

    // no coupling, last cell, snapshot every step, long output hold-off
    write_reg(CFG_COUPLING, 16'd0);
    write_reg(CFG_SOURCE_CELL, 16'd63);
    write_reg(CFG_SAVE_INTERVAL, 16'd1);
    random_steps(30);
    hold_wanted = 1'b1;
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_COUPLING, 16'($urandom));
      write_reg(CFG_SOURCE_CELL, 16'($urandom_range(63)));
      write_reg(CFG_SAVE_INTERVAL, 16'($urandom_range(4)));
      random_steps(35);
      drain();
    end

    // widest interval: after the pending snapshot the countdown runs on without further snapshots
    write_reg(CFG_COUPLING, COUPLING_RST);
    write_reg(CFG_SOURCE_CELL, 16'(SOURCE_CELL_RST));
    write_reg(CFG_SAVE_INTERVAL, 16'hFFFF);
    random_steps(12);
    drain();
    repeat (100) @(posedge clk_i);

    if (mismatches == 0 && e_samples_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
